[src/nsk_pkg.sv]
// shared constants, register and mode codes, and exp2 coefficient functions for the kernel
package nsk_pkg;

  localparam int VALUE_WIDTH_DEF     = 32;
  localparam int SCORE_FRAC_BITS_DEF = 15;

  // integer and fraction bits of the normalized excess x
  localparam int XINT         = 8;
  localparam int XFRAC        = 32;
  localparam int XW           = XINT + XFRAC;
  localparam int DIV_STEPS    = XINT + XFRAC;
  localparam int PIPE_LATENCY = 3 + DIV_STEPS + 2 + XFRAC + 1;

  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_DECAY_MODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN     = 2'd1;
  localparam logic [IDX_W-1:0] REG_BAND       = 2'd2;
  localparam logic [IDX_W-1:0] REG_SCALE      = 2'd3;

  localparam logic [2:0] MODE_STEP    = 3'd0;
  localparam logic [2:0] MODE_LINEAR  = 3'd1;
  localparam logic [2:0] MODE_SQUARED = 3'd2;
  localparam logic [2:0] MODE_EXP     = 3'd3;
  localparam logic [2:0] MODE_GAUSS   = 3'd4;
  localparam logic [2:0] MODE_RESET   = MODE_LINEAR;

  localparam logic [63:0] SCALE_RESET = 64'd65536;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] probe;
    rem   = v;
    res   = '0;
    probe = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q0.32
  function automatic logic [31:0] exp2_coef(input int k);
    logic [63:0] c;
    c = 64'h0000_0000_8000_0000;
    for (int i = 1; i <= k; i++) begin
      c = isqrt64(c << 32);
    end
    return c[31:0];
  endfunction

endpackage

[src/numeric_similarity_kernel_core.sv]
// numeric similarity kernel: distance-decay score of a sample against a configured origin
// Fully pipelined: one sample word is taken in every clock, and its score appears with a
// done strobe after the distance, excess, divider, m1, exp2 and output registers.
// The depth comes from the 40-step restoring divider that forms (distance - band) / scale
// and from the 32 multiply stages that build 2^-y for the exponential and gaussian
// decays. busy_o stays low and the receiver cannot stall. The user must see that
// configuration is written only while the pipeline is empty; the block does not enforce it.
module numeric_similarity_kernel_core #(
  parameter int VALUE_WIDTH     = nsk_pkg::VALUE_WIDTH_DEF,
  parameter int SCORE_FRAC_BITS = nsk_pkg::SCORE_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [VALUE_WIDTH-1:0]    sample_value_i,
  output logic                             done_o,
  output logic [SCORE_FRAC_BITS:0]         similarity_o,
  input  logic                             cfg_we_i,
  input  logic [nsk_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]           cfg_wdata_i
);
  import nsk_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int SFB  = SCORE_FRAC_BITS;
  localparam int SW   = SFB + 1;
  localparam int RW   = VW + XINT;
  localparam int LSH  = XFRAC + 1 - SFB;
  localparam int QSH  = 49 - SFB;
  localparam logic [SW-1:0] ONE = {1'b1, {SFB{1'b0}}};

  // configuration
  logic [2:0]    mode_q;
  logic [VW-1:0] origin_q;
  logic [VW-2:0] band_q;
  logic [VW-2:0] scale_q;
  logic [VW-2:0] scale_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RESET;
      origin_q <= '0;
      band_q   <= '0;
      scale_q  <= (VW-1)'(SCALE_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DECAY_MODE: mode_q   <= cfg_wdata_i[2:0];
        REG_ORIGIN:     origin_q <= cfg_wdata_i;
        REG_BAND:       band_q   <= cfg_wdata_i[VW-2:0];
        REG_SCALE:      scale_q  <= cfg_wdata_i[VW-2:0];
        default:        mode_q   <= mode_q;
      endcase
    end
  end

  assign scale_eff = (scale_q == '0) ? (VW-1)'(1) : scale_q;
  assign busy_o    = 1'b0;

  // stage 1: distance
  logic [VW:0]   diff_ab, diff_ba;
  logic [VW-1:0] dist_d, dist_q;
  logic          v1_q;

  assign diff_ab = {sample_value_i[VW-1], sample_value_i} - {origin_q[VW-1], origin_q};
  assign diff_ba = {origin_q[VW-1], origin_q} - {sample_value_i[VW-1], sample_value_i};
  assign dist_d  = diff_ab[VW] ? diff_ba[VW-1:0] : diff_ab[VW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  // stage 2: excess over the band
  logic [VW:0]   ediff;
  logic [VW-1:0] e_q;
  logic          inb2_q, v2_q;

  assign ediff = {1'b0, dist_q} - {2'b0, band_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= ediff[VW-1:0];
    inb2_q <= ediff[VW] | (ediff[VW-1:0] == '0);
  end

  // stage 3 and divider: x = e / scale, 8 integer and 32 fraction bits
  logic [RW-1:0] r_q   [0:DIV_STEPS];
  logic [XW-1:0] qt_q  [0:DIV_STEPS];
  logic          sat_q [0:DIV_STEPS];
  logic          inb_q [0:DIV_STEPS];
  logic          dv_q  [0:DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]   <= RW'(e_q);
    qt_q[0]  <= '0;
    sat_q[0] <= RW'(e_q) >= {1'b0, scale_eff, {XINT{1'b0}}};
    inb_q[0] <= inb2_q;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [RW-1:0] dvs;
    logic [RW-1:0] rin;
    logic          ge;
    logic [RW-1:0] rnext;

    if (j < XINT) begin : g_int
      assign dvs = RW'(scale_eff) << (XINT - 1 - j);
      assign rin = r_q[j];
    end else begin : g_frac
      assign dvs = RW'(scale_eff);
      assign rin = r_q[j] << 1;
    end

    assign ge    = ~sat_q[j] & (rin >= dvs);
    assign rnext = ge ? rin - dvs : rin;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[j+1]   <= rnext;
      qt_q[j+1]  <= {qt_q[j][XW-2:0], ge};
      sat_q[j+1] <= sat_q[j];
      inb_q[j+1] <= inb_q[j];
    end
  end

  // m1: square of x truncated to 24 fraction bits
  logic [XW-1:0] xq;
  logic [27:0]   xm;
  logic [XW-1:0] m1_x_q;
  logic [55:0]   m1_mul_q;
  logic          m1_inb_q, m1_v_q;

  assign xq = sat_q[DIV_STEPS] ? '1 : qt_q[DIV_STEPS];
  assign xm = xq[35:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else begin
      m1_v_q <= dv_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    m1_x_q   <= xq;
    m1_mul_q <= 56'(xm) * 56'(xm);
    m1_inb_q <= inb_q[DIV_STEPS];
  end

  // m2: linear and squared scores, exponent for exp2
  logic [7:0]    ip;
  logic [33:0]   lin_full;
  logic [SW-1:0] lin_score;
  logic [49:0]   sq_full;
  logic [SW-1:0] sq_score;
  logic          m2_use_d;
  logic [SW-1:0] m2_score_d;
  logic [XW-1:0] m2_y_d;

  assign ip        = m1_x_q[XW-1:XFRAC];
  assign lin_full  = {1'b0, m1_x_q[32:0]} + (34'(1) << (LSH - 1));
  assign lin_score = ONE - SW'(lin_full >> LSH);
  assign sq_full   = {1'b0, m1_mul_q[48:0]} + (50'(1) << (QSH - 1));
  assign sq_score  = ONE - SW'(sq_full >> QSH);

  always_comb begin
    m2_use_d   = 1'b0;
    m2_score_d = '0;
    m2_y_d     = m1_x_q;
    if (m1_inb_q) begin
      m2_score_d = ONE;
    end else begin
      case (mode_q)
        MODE_LINEAR: begin
          if (ip[7:1] == '0) m2_score_d = lin_score;
        end
        MODE_SQUARED: begin
          if (ip[7:1] == '0 && m1_mul_q[55:49] == '0) m2_score_d = sq_score;
        end
        MODE_EXP: begin
          m2_use_d = 1'b1;
        end
        MODE_GAUSS: begin
          if (ip[7:4] == '0) begin
            m2_use_d = 1'b1;
            m2_y_d   = m1_mul_q[55:16];
          end
        end
        default: m2_score_d = '0;
      endcase
    end
  end

  // exp2 stages: product of 2^(-2^-k) over the set fraction bits
  logic [XFRAC:0] acc_q   [0:XFRAC];
  logic [XW-1:0]  y_q     [0:XFRAC];
  logic           use_q   [0:XFRAC];
  logic [SW-1:0]  score_q [0:XFRAC];
  logic           ev_q    [0:XFRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q[0] <= 1'b0;
    end else begin
      ev_q[0] <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q[0]   <= {1'b1, {XFRAC{1'b0}}};
    y_q[0]     <= m2_y_d;
    use_q[0]   <= m2_use_d;
    score_q[0] <= m2_score_d;
  end

  for (genvar k = 1; k <= XFRAC; k++) begin : g_exp
    localparam logic [31:0] COEF = exp2_coef(k);
    logic [64:0] prod;
    logic [64:0] rnd;

    assign prod = 65'(acc_q[k-1]) * 65'(COEF);
    assign rnd  = prod + (65'(1) << (XFRAC - 1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ev_q[k] <= 1'b0;
      end else begin
        ev_q[k] <= ev_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[k]   <= y_q[k-1][XFRAC-k] ? rnd[64:XFRAC] : acc_q[k-1];
      y_q[k]     <= y_q[k-1];
      use_q[k]   <= use_q[k-1];
      score_q[k] <= score_q[k-1];
    end
  end

  // output: scale by 2^-n and pick the result
  logic [9:0]    exp_sh;
  logic [SW-1:0] exp_score;
  logic [SW-1:0] sim_d, sim_q;
  logic          done_q;

  assign exp_sh    = 10'(XFRAC - SFB) + {2'b0, y_q[XFRAC][XW-1:XFRAC]};
  assign exp_score = (exp_sh > 10'(XFRAC)) ? '0 : SW'(acc_q[XFRAC] >> exp_sh);
  assign sim_d     = use_q[XFRAC] ? exp_score : score_q[XFRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ev_q[XFRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    sim_q <= sim_d;
  end

  assign done_o       = done_q;
  assign similarity_o = sim_q;

endmodule

[src/nsk_checker.sv]
// port-level checks of latency and score range for the kernel, bound to the top level
module nsk_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic                                 done_o,
  input logic [nsk_pkg::SCORE_FRAC_BITS_DEF:0] similarity_o
);
  import nsk_pkg::*;

  localparam logic [SCORE_FRAC_BITS_DEF:0] ONE = {1'b1, {SCORE_FRAC_BITS_DEF{1'b0}}};

  a_done_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, PIPE_LATENCY))
    else $error("result word without a matching start");

  a_word_gets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##PIPE_LATENCY done_o)
    else $error("accepted word produced no result");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (similarity_o <= ONE))
    else $error("similarity above one");

endmodule

bind numeric_similarity_kernel_core nsk_checker u_nsk_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .similarity_o (similarity_o)
);

[test/numeric_similarity_kernel_core_test.sv]
// self-checking testbench for the numeric similarity kernel: directed table, then random words
`timescale 1ns / 100ps

module numeric_similarity_kernel_core_test;
  import nsk_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [15:0] SCORE_ONE = 16'd32768;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] origin;
    logic [31:0] band;
    logic [31:0] scale;
    logic [31:0] sample;
    int          score;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic signed [31:0] sample_value_i;
  logic        done_o;
  logic [15:0] similarity_o;
  logic        cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  logic [2:0]  mode_q;
  logic [31:0] origin_q;
  logic [30:0] band_q;
  logic [30:0] scale_q;
  int          typed_score;
  logic [63:0] half_coef [1:32];

  logic [15:0] score_queue [$];
  int          fail_count;
  int          sent_count;
  int          result_count;
  int          idle_cycles;
  int          idle_pct;

  numeric_similarity_kernel_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .sample_value_i(sample_value_i),
    .done_o        (done_o),
    .similarity_o  (similarity_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem   = v;
    res   = '0;
    bit_w = 64'h1 << 62;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] frac_quotient(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    q = '0;
    for (int n = 0; n < 32; n++) begin
      q = q << 1;
      if (num >= den - num) begin
        num = num - (den - num);
        q[0] = 1'b1;
      end else begin
        num = num + num;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] pow2_neg(input logic [63:0] y);
    logic [63:0] acc;
    logic [63:0] sh;
    acc = 64'h1 << 32;
    for (int k = 1; k <= 32; k++) begin
      if (y[32-k]) acc = (acc * half_coef[k] + (64'h1 << 31)) >> 32;
    end
    sh = 64'd17 + (y >> 32);
    if (sh >= 64) return '0;
    return acc >> sh;
  endfunction

  function automatic logic [15:0] similarity_of(input logic [31:0] sample);
    longint      a;
    longint      b;
    logic [63:0] distance;
    logic [63:0] excess;
    logic [63:0] ip;
    logic [63:0] x;
    logic [63:0] xs;
    logic [63:0] q;
    logic [63:0] scale;
    logic [63:0] score;
    a        = longint'(signed'(sample));
    b        = longint'(signed'(origin_q));
    scale    = (scale_q == 0) ? 64'd1 : 64'(scale_q);
    distance = (a >= b) ? 64'(a - b) : 64'(b - a);
    if (distance <= 64'(band_q)) return SCORE_ONE;
    if (!(mode_q inside {MODE_LINEAR, MODE_SQUARED, MODE_EXP, MODE_GAUSS})) return '0;
    excess = distance - 64'(band_q);
    ip     = excess / scale;
    if (ip > 255) x = (64'd255 << 32) | 64'hffff_ffff;
    else x = (ip << 32) | frac_quotient(excess % scale, scale);
    case (mode_q)
      MODE_LINEAR: begin
        if (ip >= 2) score = 0;
        else score = 64'(SCORE_ONE) - ((x + (64'h1 << 17)) >> 18);
      end
      MODE_SQUARED: begin
        xs = x >> 8;
        q  = xs * xs;
        if (ip >= 2 || q >= (64'd2 << 48)) score = 0;
        else score = 64'(SCORE_ONE) - ((q + (64'h1 << 33)) >> 34);
      end
      MODE_EXP: score = pow2_neg(x);
      default: begin
        xs = x >> 8;
        if (ip >= 16) score = 0;
        else score = pow2_neg((xs * xs) >> 16);
      end
    endcase
    return score[15:0];
  endfunction

  // scoreboard: predict on accepted words, check every strobed result
  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        want = (typed_score >= 0) ? 16'(typed_score) : similarity_of(sample_value_i);
        score_queue.push_back(want);
      end
      if (done_o) begin
        result_count++;
        if (score_queue.size() == 0) begin
          $display("%0t: unexpected score, expected none, actual %0d", $time, similarity_o);
          fail_count++;
        end else begin
          want = score_queue.pop_front();
          if (want !== similarity_o) begin
            $display("%0t: similarity mismatch, expected %0d, actual %0d",
                     $time, want, similarity_o);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("numeric_similarity_kernel_core regression: fail");
      $finish;
    end
  end

  task automatic drain_pipe();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (score_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_DECAY_MODE: mode_q   = value[2:0];
      REG_ORIGIN:     origin_q = value;
      REG_BAND:       band_q   = value[30:0];
      default:        scale_q  = value[30:0];
    endcase
  endtask

  task automatic load_setting(input logic [2:0] mode, input logic [31:0] origin,
                              input logic [31:0] band, input logic [31:0] scale);
    drain_pipe();
    write_reg(REG_DECAY_MODE, 32'(mode));
    write_reg(REG_ORIGIN, origin);
    write_reg(REG_BAND, band);
    write_reg(REG_SCALE, scale);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(input logic [31:0] sample, input int score);
    logic busy_seen;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    sample_value_i <= sample;
    typed_score    <= score;
    do begin
      @(negedge clk_i);
      busy_seen = busy_o;
      @(posedge clk_i);
    end while (busy_seen);
    sent_count++;
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'h7fff_ffff;
      3: return 32'(65536);
      4: return 32'($urandom_range(1, 1 << 20));
      default: return {1'b0, 31'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_band();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 1 << 18));
      default: return {1'b0, 31'($urandom)};
    endcase
  endfunction

  stim_row_t directed_rows [] = '{
    '{MODE_RESET, 32'd0, 32'd0, 32'd65536, 32'd0, 32768},
    '{MODE_RESET, 32'd0, 32'd0, 32'd65536, 32'd65536, 16384},
    '{MODE_RESET, 32'd0, 32'd0, 32'd65536, 32'hffff_0000, 16384},
    '{MODE_RESET, 32'd0, 32'd0, 32'd65536, 32'd131072, 0},
    '{MODE_RESET, 32'd0, 32'd0, 32'd65536, 32'd12345, -1},
    '{MODE_STEP, 32'd100, 32'd50, 32'd65536, 32'd150, 32768},
    '{MODE_STEP, 32'd100, 32'd50, 32'd65536, 32'd151, 0},
    '{3'd5, 32'd100, 32'd50, 32'd65536, 32'd200, 0},
    '{3'd7, 32'd100, 32'd50, 32'd65536, 32'd120, 32768},
    '{MODE_SQUARED, 32'd0, 32'd0, 32'd65536, 32'd65536, 16384},
    '{MODE_SQUARED, 32'd0, 32'd0, 32'd65536, 32'd70000, -1},
    '{MODE_SQUARED, 32'd0, 32'd0, 32'd65536, 32'd100000, 0},
    '{MODE_EXP, 32'd0, 32'd0, 32'd65536, 32'd65536, 16384},
    '{MODE_EXP, 32'd0, 32'd0, 32'd65536, 32'd32768, -1},
    '{MODE_EXP, 32'd0, 32'd0, 32'd65536, 32'h7fff_ffff, 0},
    '{MODE_GAUSS, 32'd0, 32'd0, 32'd65536, 32'd65536, 16384},
    '{MODE_GAUSS, 32'd0, 32'd0, 32'd65536, 32'd50000, -1},
    '{MODE_GAUSS, 32'd0, 32'd0, 32'd65536, 32'h0010_0000, 0},
    '{MODE_LINEAR, 32'd0, 32'd0, 32'd0, 32'd1, 16384},
    '{MODE_LINEAR, 32'h8000_0000, 32'd0, 32'd65536, 32'h7fff_ffff, 0},
    '{MODE_EXP, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, -1},
    '{MODE_GAUSS, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'h8000_0000, -1},
    '{MODE_LINEAR, 32'h7fff_ffff, 32'd0, 32'h7fff_ffff, 32'h8000_0000, -1}
  };

  initial begin
    logic [63:0] c;
    logic [2:0]  mode;
    logic [31:0] band;
    logic [31:0] scale;
    logic [31:0] origin;
    logic [63:0] offset;
    int          setting_count;
    start_i        = 1'b0;
    sample_value_i = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_DECAY_MODE;
    cfg_wdata_i    = '0;
    typed_score    = -1;
    sent_count     = 0;
    idle_pct       = 0;
    setting_count  = 0;
    mode_q   = MODE_RESET;
    origin_q = '0;
    band_q   = '0;
    scale_q  = 31'(SCALE_RESET);
    c = 64'h8000_0000;
    for (int k = 1; k <= 32; k++) begin
      c = root_floor(c << 32);
      half_coef[k] = c;
    end
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != mode_q || directed_rows[i].origin != origin_q ||
          directed_rows[i].band[30:0] != band_q || directed_rows[i].scale[30:0] != scale_q) begin
        load_setting(directed_rows[i].mode, directed_rows[i].origin,
                     directed_rows[i].band, directed_rows[i].scale);
        setting_count++;
      end
      send_word(directed_rows[i].sample, directed_rows[i].score);
    end

    for (int blk = 0; blk < 10; blk++) begin
      idle_pct = (blk < 4) ? 11 : (blk < 7) ? 68 : 0;
      mode   = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      origin = (blk == 0) ? 32'h8000_0000 : (blk == 1) ? 32'h7fff_ffff : $urandom;
      band   = pick_band();
      scale  = pick_scale();
      load_setting(mode, origin, band, scale);
      setting_count++;
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(3) == 0) begin
          send_word($urandom, -1);
        end else begin
          offset = 64'(band_q) + ($urandom % (64'(scale_q) * 3 + 1));
          if ($urandom_range(1)) send_word(origin_q + offset[31:0], -1);
          else send_word(origin_q - offset[31:0], -1);
        end
      end
    end

    drain_pipe();
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    $display("covered %0d sample words, %0d scores checked, %0d register settings",
             sent_count, result_count, setting_count);
    $display("all decay modes incl. unused codes, zero and extreme scale, band and origin");
    if (fail_count == 0 && score_queue.size() == 0) begin
      $display("numeric_similarity_kernel_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d scores never seen", fail_count, score_queue.size());
      $display("numeric_similarity_kernel_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/nsk_pkg.sv
src/numeric_similarity_kernel_core.sv
src/nsk_checker.sv
test/numeric_similarity_kernel_core_test.sv
